FILE: design/text_mode_terminal_writer_top_macros.svh
// Assertion helpers for the terminal writer. Both expect clk and rst_n in scope.
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_MACROS_SVH

// Same-cycle implication
`define TMTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tmtw_pkg.sv
`default_nettype none

package tmtw_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } tmtw_cmd_t;

  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h25;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] cell_color;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
  } tmtw_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } tmtw_out_t;

endpackage

`default_nettype wire

FILE: design/text_mode_terminal_writer_top.sv
// Text-mode terminal writer: a ROWS x COLUMNS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) with a cursor. After reset the block
// sweeps the whole store to a space in color 0x25, one cell per cycle, and in_stall
// stays high until the sweep is done. Every command then goes through accept, execute
// and hand to the output register, using a single-port-write, single-port-read
// screen memory. A put-char or newline that runs past the last row also scrolls the
// screen up one row: each cell moved is read in ST_SCROLL_RD and written back in
// ST_SCROLL_WR. The bottom row keeps its old text. The
// output is registered, so the next command is taken while a result waits on
// out_stall. text_color may only be written while the block is idle.
`default_nettype none
`include "text_mode_terminal_writer_top_macros.svh"

module text_mode_terminal_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tmtw_pkg::tmtw_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tmtw_pkg::tmtw_out_t     out_data
);

  import tmtw_pkg::*;

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] CLEAR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ROW_W:0]    ROW_LIM     = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]    COL_LIM     = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR     = 6'b000001,
    ST_IDLE      = 6'b000010,
    ST_EXEC      = 6'b000100,
    ST_SCROLL_RD = 6'b001000,
    ST_SCROLL_WR = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ROW_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [ATTR_W-1:0] text_color_r;
  tmtw_in_t          item_r;
  logic              out_valid_r;
  tmtw_out_t         out_data_r;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // shared adder: cell address, scroll source address, sweep index step
  logic [ADDR_W-1:0] au_a, au_b, au_sum;

  logic              is_put, in_range, in_xfer, out_load;
  logic [ROW_W-1:0]  exec_row;
  logic [COL_W-1:0]  exec_col;
  logic [ADDR_W-1:0] row_base;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              row_over;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  assign is_put   = (item_r.cmd == CMD_PUT);
  assign in_range = ({1'b0, item_r.cell_row} < ROW_LIM) && ({1'b0, item_r.cell_col} < COL_LIM);
  assign exec_row = is_put ? cursor_row_r : item_r.cell_row;
  assign exec_col = is_put ? cursor_col_r : item_r.cell_col;
  assign row_base = ADDR_W'(exec_row) * COLS_A;
  assign col_inc  = {1'b0, cursor_col_r} + (COL_W + 1)'(1);
  assign row_inc  = {1'b0, cursor_row_r} + (ROW_W + 1)'(1);
  assign row_over = (row_inc >= ROW_LIM);
  assign au_sum   = au_a + au_b;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    au_a           = idx_r;
    au_b           = ADDR_W'(1);
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = {RESET_COLOR, CH_SPACE};
        idx_nxt = au_sum;
        if (idx_r == CLEAR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        au_a      = row_base;
        au_b      = ADDR_W'(exec_col);
        wr_addr   = au_sum;
        idx_nxt   = '0;
        state_nxt = ST_FINISH;
        priority case (1'b1)
          is_put: begin
            if (item_r.char_code != CH_NEWLINE) begin
              wr_en          = 1'b1;
              wr_data        = {text_color_r, item_r.char_code};
              cursor_col_nxt = col_inc[COL_W-1:0];
            end
            if (item_r.char_code == CH_NEWLINE || col_inc >= COL_LIM) begin
              cursor_col_nxt = '0;
              if (row_over) begin
                cursor_row_nxt = ROW_LAST;
                state_nxt      = ST_SCROLL_RD;
              end else begin
                cursor_row_nxt = row_inc[ROW_W-1:0];
              end
            end
          end
          (item_r.cmd == CMD_WRITE): begin
            wr_en   = in_range;
            wr_data = {item_r.cell_color, item_r.char_code};
          end
          (item_r.cmd == CMD_READ): begin
            rd_en = in_range;
          end
          default: begin
          end
        endcase
      end
      ST_SCROLL_RD: begin
        // fetch the cell one row below the destination
        au_b      = COLS_A;
        rd_en     = 1'b1;
        state_nxt = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = au_sum;
        state_nxt = (idx_r == SCROLL_LAST) ? ST_FINISH : ST_SCROLL_RD;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      cursor_row_r <= '0;
      cursor_col_r <= '0;
      text_color_r <= RESET_COLOR;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r.cell_data  <= (item_r.cmd == CMD_READ && in_range) ? rd_data_r : '0;
      out_data_r.cursor_row <= cursor_row_r;
      out_data_r.cursor_col <= cursor_col_r;
    end
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[au_sum];
    end
  end

  `TMTW_ASSERT_NEXT(a_accept_exec, in_xfer, state_r == ST_EXEC, "accepted item did not execute")
  `TMTW_ASSERT_NOW(a_row_range, 1'b1, {1'b0, cursor_row_r} < ROW_LIM, "cursor row out of range")
  `TMTW_ASSERT_NOW(a_col_range, 1'b1, {1'b0, cursor_col_r} < COL_LIM, "cursor col out of range")
  `TMTW_ASSERT_NOW(a_no_idle_wr, state_r == ST_IDLE || state_r == ST_FINISH, !wr_en,
                   "screen written outside a command")
  `TMTW_ASSERT_NOW(a_scroll_row, state_r == ST_SCROLL_WR, cursor_row_r == ROW_LAST,
                   "scroll with cursor off the last row")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tmtw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int PHASE_ITEMS = 350;

  typedef struct packed {
    bit        typed;
    tmtw_in_t  stim;
    tmtw_out_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tmtw_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tmtw_out_t out_data;

  // screen shadow and cursor
  logic [CELL_W-1:0] screen_m [ROWS*COLS];
  int                row_m;
  int                col_m;
  logic [ATTR_W-1:0] text_color_m;

  tmtw_out_t due_results [$];
  tmtw_in_t  pending [$];
  tmtw_out_t got_want;
  int        mismatches = 0;
  int        cycles = 0;
  bit        no_idle = 1'b0;

  // directed rows; typed expectations where the answer is obvious
  dir_row_t dir_tab [26] = '{
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd0,  7'd0},   '{16'h2520, 5'd0, 7'd0}},
    '{1'b1, '{CMD_READ,  8'hFF, 8'hFF, 5'd31, 7'd127}, '{16'h0000, 5'd0, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd24, 7'd80},  '{16'h0000, 5'd0, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd25, 7'd0},   '{16'h0000, 5'd0, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd24, 7'd79},  '{16'h2520, 5'd0, 7'd0}},
    '{1'b1, '{CMD_PUT,   8'h41, 8'hFF, 5'd31, 7'd127}, '{16'h0000, 5'd0, 7'd1}},
    '{1'b1, '{CMD_PUT,   8'h00, 8'h00, 5'd0,  7'd0},   '{16'h0000, 5'd0, 7'd2}},
    '{1'b1, '{CMD_PUT,   8'hFF, 8'h00, 5'd0,  7'd0},   '{16'h0000, 5'd0, 7'd3}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd0,  7'd0},   '{16'h2541, 5'd0, 7'd3}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd0,  7'd2},   '{16'h25FF, 5'd0, 7'd3}},
    '{1'b1, '{CMD_PUT,   CH_NEWLINE, 8'h00, 5'd0, 7'd0}, '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, 8'hFF, 8'hFF, 5'd24, 7'd79},  '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd24, 7'd79},  '{16'hFFFF, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, 8'h00, 8'h00, 5'd0,  7'd0},   '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd0,  7'd0},   '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, CH_NEWLINE, 8'h3C, 5'd2, 7'd5}, '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd2,  7'd5},   '{16'h3C0A, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, 8'hFF, 8'hFF, 5'd25, 7'd0},   '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, 8'h55, 8'hAA, 5'd0,  7'd80},  '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_WRITE, 8'h12, 8'h34, 5'd31, 7'd127}, '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd1,  7'd0},   '{16'h2520, 5'd1, 7'd0}},
    '{1'b1, '{CMD_NOP,   CH_NEWLINE, 8'h00, 5'd0, 7'd0}, '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_NOP,   8'hFF, 8'hFF, 5'd31, 7'd127}, '{16'h0000, 5'd1, 7'd0}},
    '{1'b1, '{CMD_READ,  8'h00, 8'h00, 5'd0,  7'd79},  '{16'h2520, 5'd1, 7'd0}},
    '{1'b0, '{CMD_PUT,   8'h7E, 8'h5A, 5'd16, 7'd64},  '0},
    '{1'b0, '{CMD_READ,  8'hA5, 8'h00, 5'd1,  7'd0},   '0}
  };

  text_mode_terminal_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = !no_idle && ($urandom_range(0, 99) < 35);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        mismatches++;
      end else begin
        got_want = due_results.pop_front();
        if (got_want.cell_data !== out_data.cell_data) begin
          $error("cell_data: expected %h, actual %h", got_want.cell_data, out_data.cell_data);
          mismatches++;
        end
        if (got_want.cursor_row !== out_data.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d",
                 got_want.cursor_row, out_data.cursor_row);
          mismatches++;
        end
        if (got_want.cursor_col !== out_data.cursor_col) begin
          $error("cursor_col: expected %0d, actual %0d",
                 got_want.cursor_col, out_data.cursor_col);
          mismatches++;
        end
      end
    end
  end

  // row advance; past the bottom the screen moves up and the last row keeps its text
  task line_feed;
    int i;
    row_m++;
    if (row_m >= ROWS) begin
      row_m = ROWS - 1;
      for (i = 0; i < (ROWS - 1) * COLS; i++) screen_m[i] = screen_m[i + COLS];
    end
  endtask

  task screen_model_step(input tmtw_in_t c, output tmtw_out_t r);
    bit hit;
    int addr;
    hit  = (c.cell_row < ROWS) && (c.cell_col < COLS);
    addr = c.cell_row * COLS + c.cell_col;
    r = '0;
    case (tmtw_cmd_t'(c.cmd))
      CMD_PUT: begin
        if (c.char_code == CH_NEWLINE) begin
          col_m = 0;
          line_feed();
        end else begin
          screen_m[row_m * COLS + col_m] = {text_color_m, c.char_code};
          col_m++;
          if (col_m >= COLS) begin
            col_m = 0;
            line_feed();
          end
        end
      end
      CMD_WRITE: if (hit) screen_m[addr] = {c.cell_color, c.char_code};
      CMD_READ: if (hit) r.cell_data = screen_m[addr];
      default: ;
    endcase
    r.cursor_row = row_m[ROW_W-1:0];
    r.cursor_col = col_m[COL_W-1:0];
  endtask

  task send_cmd(input tmtw_in_t it, input bit typed, input tmtw_out_t want);
    tmtw_out_t r;
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    screen_model_step(it, r);
    due_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task wait_idle;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_color(input logic [ATTR_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    text_color_m = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic tmtw_in_t rand_fields(input tmtw_cmd_t op);
    tmtw_in_t f;
    f.cmd        = op;
    f.char_code  = CHAR_W'($urandom_range(0, 255));
    f.cell_color = ATTR_W'($urandom_range(0, 255));
    f.cell_row   = ROW_W'($urandom_range(0, 31));
    f.cell_col   = COL_W'($urandom_range(0, 127));
    return f;
  endfunction

  // mostly on screen, leaning toward the bottom rows where scrolled text lands
  function automatic tmtw_in_t aim_cell(input tmtw_in_t f);
    if ($urandom_range(0, 99) < 85) begin
      f.cell_row = $urandom_range(0, 1) ? ROW_W'($urandom_range(ROWS - 5, ROWS - 1))
                                        : ROW_W'($urandom_range(0, ROWS - 1));
      f.cell_col = COL_W'($urandom_range(0, COLS - 1));
    end else if ($urandom_range(0, 1)) begin
      f.cell_row = ROW_W'($urandom_range(ROWS, 31));
    end else begin
      f.cell_col = COL_W'($urandom_range(COLS, 127));
    end
    return f;
  endfunction

  task add_segment;
    int kind;
    int n;
    int k;
    tmtw_in_t it;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // a line of text, now and then long enough to wrap
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(79, 170) : $urandom_range(0, 60);
      for (k = 0; k < n; k++) begin
        it = rand_fields(CMD_PUT);
        while (it.char_code == CH_NEWLINE) it.char_code = CHAR_W'($urandom_range(0, 255));
        pending.push_back(it);
      end
      if ($urandom_range(0, 9) < 7) begin
        it = rand_fields(CMD_PUT);
        it.char_code = CH_NEWLINE;
        pending.push_back(it);
      end
    end else if (kind < 50) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        it = rand_fields(CMD_PUT);
        it.char_code = CH_NEWLINE;
        pending.push_back(it);
      end
    end else if (kind < 75) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
        it = aim_cell(rand_fields(CMD_WRITE));
        pending.push_back(it);
        if ($urandom_range(0, 1)) begin
          it.cmd = CMD_READ;
          pending.push_back(it);
        end
      end
    end else if (kind < 95) begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) pending.push_back(aim_cell(rand_fields(CMD_READ)));
    end else begin
      n = $urandom_range(1, 2);
      for (k = 0; k < n; k++) pending.push_back(rand_fields(CMD_NOP));
    end
  endtask

  initial begin
    int i;
    int ph;
    logic [ATTR_W-1:0] colors [4];
    tmtw_in_t it;

    for (i = 0; i < ROWS * COLS; i++) screen_m[i] = {RESET_COLOR, CH_SPACE};
    row_m = 0;
    col_m = 0;
    text_color_m = RESET_COLOR;
    colors[0] = 8'h00;
    colors[1] = 8'hFF;
    colors[2] = ATTR_W'($urandom_range(0, 255));
    colors[3] = ATTR_W'($urandom_range(0, 255));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < $size(dir_tab); i++)
      send_cmd(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    in_valid = 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_color(colors[ph]);
      no_idle = (ph == 1);
      while (pending.size() < PHASE_ITEMS) add_segment();
      while (pending.size() != 0) begin
        it = pending.pop_front();
        send_cmd(it, 1'b0, '0);
      end
      in_valid = 1'b0;
      no_idle  = 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
